// ----- hw/rtl/b58_pkg.sv -----
// Shared constants, item types, sequencer states and the alphabet lookup of the base58 encoder.
package b58_pkg;

    // Default byte capacity of the input store
    localparam int MAX_BYTES_DEF = 32;
    // Most characters ever emitted for one string
    localparam int MAX_CHARS     = 44;
    // Digit scratch memory
    localparam int DIGIT_SLOTS   = 64;
    localparam int DIGIT_AW      = 6;
    localparam int DIGIT_CNT_W   = DIGIT_AW + 1;
    // Emitted character counter
    localparam int CHAR_CNT_W    = $clog2(MAX_CHARS + 1);
    // Divide by 58: floor(v * RECIP58 / 2**RECIP_SHIFT) is exact for v < 58 * 256
    localparam int RECIP58       = 1130;
    localparam int RECIP_SHIFT   = 16;
    localparam int DIV_IN_W      = 14;
    localparam int PROD_W        = 25;
    // ASCII '1', the character for a leading zero byte and for digit zero
    localparam logic [6:0] CHAR_ONE = 7'd49;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
        logic       truncated;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PASS,
        ST_EMIT
    } b58_state_t;

    // Bitcoin alphabet: digit to ASCII, the gaps skip 0, I, O and l
    function automatic logic [6:0] b58_char(input logic [5:0] digit);
        logic [6:0] d;
        logic [6:0] code;
        d = {1'b0, digit};
        priority if (digit <= 6'd8)
            code = d + 7'd49;
        else if (digit <= 6'd16)
            code = d + 7'd56;
        else if (digit <= 6'd21)
            code = d + 7'd57;
        else if (digit <= 6'd32)
            code = d + 7'd58;
        else if (digit <= 6'd43)
            code = d + 7'd64;
        else if (digit <= 6'd57)
            code = d + 7'd65;
        else
            code = 7'd122;
        return code;
    endfunction

endpackage

// ----- hw/rtl/b58_chan_if.sv -----
// Valid/ready channel interface carrying one request payload.
interface b58_chan_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/b58_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module b58_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/b58_div58.sv -----
// One step of long division by 58: {remainder, byte} -> quotient byte and new remainder.
module b58_div58
    import b58_pkg::*;
(
    input  logic [DIV_IN_W-1:0] value,
    output logic [7:0]          quot,
    output logic [5:0]          rem
);

    logic [PROD_W-1:0] prod;
    logic [5:0]        q58_lo;

    // Reciprocal multiply, exact over the operand range
    assign prod = PROD_W'(value) * PROD_W'(RECIP58);
    assign quot = prod[RECIP_SHIFT+7:RECIP_SHIFT];

    // Remainder is below 64, so only the low six bits of q*58 matter
    assign q58_lo = {quot[0], 5'b0} + {quot[1:0], 4'b0} + {quot[2:0], 3'b0} + {quot[4:0], 1'b0};
    assign rem    = value[5:0] - q58_lo;

endmodule

// ----- hw/rtl/base58_encoder.sv -----
// Base58 encoder top level: byte store, division sequencer and character output.
//
//  channel      | dir | payload                               | accepted when
//  -------------+-----+---------------------------------------+------------------
//  byte_stream  | in  | data_byte[7:0], last_byte             | valid && ready
//  char_stream  | out | char_code[6:0], last_char, truncated  | valid && ready
//
//  Load: one byte per cycle; ready is high only in the load state.
//  Convert: each pass divides the live bytes by 58 through the byte RAM;
//  about 1.37 passes per byte.
//  Emit: a leading '1' goes straight to the output register, a digit via a digit RAM read.
//  Reset clears control state only; the RAMs hold garbage until written, no clearing pass.
//  A stalled char_stream holds the emit state; the next string may load while the
//  final character still waits in the output register.
module base58_encoder
    import b58_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    b58_chan_if.sink          byte_stream,
    b58_chan_if.source        char_stream
);

    localparam int CNT_W  = $clog2(MAX_BYTES + 1);
    localparam int AW     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int DCNT_W = DIGIT_CNT_W;
    localparam int TOT_W  = ((CNT_W > DCNT_W) ? CNT_W : DCNT_W) + 1;

    b58_state_t state_reg, state_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      zeros_reg, zeros_next;
    logic                  lead_nz_reg, lead_nz_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [5:0]            rem_reg, rem_next;
    logic                  rdv_reg, rdv_next;
    logic [CNT_W-1:0]      wb_idx_reg, wb_idx_next;
    logic                  nz_seen_reg, nz_seen_next;
    logic [CNT_W-1:0]      first_nz_reg, first_nz_next;
    logic [DCNT_W-1:0]     dcount_reg, dcount_next;
    logic [DCNT_W-1:0]     dsel_reg, dsel_next;
    logic [CHAR_CNT_W-1:0] k_reg, k_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    in_item_t in_item;
    logic     in_fire;
    logic     byte_ok;
    logic     load_zero;
    logic [CNT_W-1:0] zeros_inc;
    logic [CNT_W-1:0] count_inc;
    logic     start_empty;

    logic [7:0]  byte_rdata;
    logic [5:0]  digit_rdata;
    logic [7:0]  quot;
    logic [5:0]  rem;
    logic        rd_issue;
    logic        pass_end;
    logic        value_zero;
    logic [CNT_W-1:0]  first_new;
    logic [DCNT_W-1:0] dcount_inc;
    logic [DCNT_W-1:0] dsel_dec;
    logic        pass_stop;

    logic        byte_we;
    logic [AW-1:0] byte_waddr;
    logic [7:0]  byte_wdata;

    logic [TOT_W-1:0] total;
    logic             over;
    logic [TOT_W-1:0] emit_total;
    logic             trunc;
    logic             slot_free;
    logic [TOT_W-1:0] k_ext;
    logic             in_zeros;
    logic             issue_emit;
    logic             load_one;
    logic             issue_digit;
    logic             load_char;
    logic             char_last;
    logic             emit_done;

    // Input side
    assign in_item   = byte_stream.payload;
    assign in_fire   = byte_stream.valid && byte_stream.ready;
    assign byte_ok   = count_reg < CNT_W'(MAX_BYTES);
    assign load_zero = byte_ok && !lead_nz_reg && (in_item.data_byte == 8'd0);
    assign zeros_inc = zeros_reg + CNT_W'(load_zero);
    assign count_inc = count_reg + CNT_W'(byte_ok);
    assign start_empty = (zeros_inc == count_inc);

    // Division pass control
    assign rd_issue   = (state_reg == ST_PASS) && (idx_reg < count_reg);
    assign pass_end   = (state_reg == ST_PASS) && rdv_reg && (wb_idx_reg == count_reg - CNT_W'(1));
    assign value_zero = !nz_seen_reg && (quot == 8'd0);
    assign first_new  = nz_seen_reg ? first_nz_reg : ((quot != 8'd0) ? wb_idx_reg : count_reg);
    assign dcount_inc = dcount_reg + DCNT_W'(1);
    assign dsel_dec   = dsel_reg - DCNT_W'(1);
    assign pass_stop  = pass_end && (value_zero || (dcount_inc == DCNT_W'(DIGIT_SLOTS)));

    // Emission control
    assign total      = TOT_W'(zeros_reg) + TOT_W'(dcount_reg);
    assign over       = total > TOT_W'(MAX_CHARS);
    assign emit_total = over ? TOT_W'(MAX_CHARS) : total;
    assign trunc      = ovf_reg || over;
    assign slot_free  = !out_valid_reg || char_stream.ready;
    assign k_ext      = TOT_W'(k_reg);
    assign in_zeros   = k_ext < TOT_W'(zeros_reg);
    assign issue_emit = (state_reg == ST_EMIT) && !pend_reg && slot_free && (k_ext < emit_total);
    assign load_one    = issue_emit && in_zeros;
    assign issue_digit = issue_emit && !in_zeros;
    assign load_char   = load_one || ((state_reg == ST_EMIT) && pend_reg);
    assign char_last   = (k_ext + TOT_W'(1)) == emit_total;
    assign emit_done   = load_char && char_last;

    // Byte store: written on load and by each division step
    assign byte_we    = ((state_reg == ST_LOAD) && in_fire && byte_ok) ||
                        ((state_reg == ST_PASS) && rdv_reg);
    assign byte_waddr = (state_reg == ST_LOAD) ? count_reg[AW-1:0] : wb_idx_reg[AW-1:0];
    assign byte_wdata = (state_reg == ST_LOAD) ? in_item.data_byte : quot;

    b58_ram #(
        .DEPTH (MAX_BYTES),
        .WIDTH (8)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (byte_rdata)
    );

    b58_div58 u_div (
        .value ({rem_reg, byte_rdata}),
        .quot  (quot),
        .rem   (rem)
    );

    // Digit store: one remainder per pass, read back most significant first
    b58_ram #(
        .DEPTH (DIGIT_SLOTS),
        .WIDTH (6)
    ) u_digit_ram (
        .clk   (clk),
        .we    (pass_end),
        .waddr (dcount_reg[DIGIT_AW-1:0]),
        .wdata (rem),
        .raddr (dsel_dec[DIGIT_AW-1:0]),
        .rdata (digit_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_item.last_byte)
                begin
                    state_next = start_empty ? ST_EMIT : ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (pass_stop)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        zeros_next     = zeros_reg;
        lead_nz_next   = lead_nz_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        rdv_next       = 1'b0;
        wb_idx_next    = wb_idx_reg;
        nz_seen_next   = nz_seen_reg;
        first_nz_next  = first_nz_reg;
        dcount_next    = dcount_reg;
        dsel_next      = dsel_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;

        byte_stream.ready = (state_reg == ST_LOAD);

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    count_next   = count_inc;
                    zeros_next   = zeros_inc;
                    lead_nz_next = lead_nz_reg || (byte_ok && (in_item.data_byte != 8'd0));
                    ovf_next     = ovf_reg || !byte_ok;
                    if (in_item.last_byte)
                    begin
                        idx_next     = zeros_inc;
                        rem_next     = 6'd0;
                        nz_seen_next = 1'b0;
                        dcount_next  = '0;
                        dsel_next    = '0;
                        k_next       = '0;
                        pend_next    = 1'b0;
                    end
                end
            end
            ST_PASS:
            begin
                // issue the next byte read
                rdv_next = rd_issue;
                if (rd_issue)
                begin
                    idx_next    = idx_reg + CNT_W'(1);
                    wb_idx_next = idx_reg;
                end
                // consume returned byte, carry the remainder
                if (rdv_reg)
                begin
                    rem_next = rem;
                    if ((quot != 8'd0) && !nz_seen_reg)
                    begin
                        nz_seen_next  = 1'b1;
                        first_nz_next = wb_idx_reg;
                    end
                end
                // end of pass: store digit, restart at the first live byte
                if (pass_end)
                begin
                    dcount_next  = dcount_inc;
                    dsel_next    = dcount_inc;
                    rem_next     = 6'd0;
                    nz_seen_next = 1'b0;
                    idx_next     = first_new;
                end
            end
            ST_EMIT:
            begin
                if (issue_digit)
                begin
                    pend_next = 1'b1;
                    dsel_next = dsel_dec;
                end
                if (load_char)
                begin
                    k_next    = k_reg + CHAR_CNT_W'(1);
                    pend_next = 1'b0;
                end
                if (emit_done)
                begin
                    count_next   = '0;
                    zeros_next   = '0;
                    lead_nz_next = 1'b0;
                    ovf_next     = 1'b0;
                end
            end
            default:
            begin
                rdv_next = 1'b0;
            end
        endcase

        // Output register
        out_item_next = out_item_reg;
        if (load_char)
        begin
            out_valid_next          = 1'b1;
            out_item_next.char_code = pend_reg ? b58_char(digit_rdata) : CHAR_ONE;
            out_item_next.last_char = char_last;
            out_item_next.truncated = trunc;
        end
        else if (char_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign char_stream.valid   = out_valid_reg;
    assign char_stream.payload = out_item_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            zeros_reg     <= '0;
            lead_nz_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            nz_seen_reg   <= 1'b0;
            dcount_reg    <= '0;
            dsel_reg      <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            zeros_reg     <= zeros_next;
            lead_nz_reg   <= lead_nz_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            rdv_reg       <= rdv_next;
            nz_seen_reg   <= nz_seen_next;
            dcount_reg    <= dcount_next;
            dsel_reg      <= dsel_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        wb_idx_reg   <= wb_idx_next;
        first_nz_reg <= first_nz_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ----- hw/rtl/b58_checker.sv -----
// Port-level checks for the base58 encoder, bound to the top level.
module b58_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] out_code,
    input logic       out_last,
    input logic       out_trunc
);

    // A stalled character holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_code) &&
            $stable(out_last) && $stable(out_trunc))
        else $error("stalled character changed");

    // Characters come from the alphabet range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_code >= 7'd49) && (out_code <= 7'd122))
        else $error("character outside alphabet range");

    // The last byte of a string closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input open right after end of string");

    // The truncation flag is the same on every character of a string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !out_valid || (out_trunc == $past(out_trunc)))
        else $error("truncation flag changed within a string");

endmodule

bind base58_encoder b58_checker u_b58_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_stream.valid),
    .in_ready  (byte_stream.ready),
    .in_last   (byte_stream.payload.last_byte),
    .out_valid (char_stream.valid),
    .out_ready (char_stream.ready),
    .out_code  (char_stream.payload.char_code),
    .out_last  (char_stream.payload.last_char),
    .out_trunc (char_stream.payload.truncated)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the base58 encoder: byte strings in, checked characters out.
`timescale 1ns / 100ps

module tb;
    import b58_pkg::*;

    localparam int CAPACITY     = MAX_BYTES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 6000;
    localparam int TAIL_CYCLES  = 80;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    b58_chan_if #(.item_t(in_item_t))  byte_if ();
    b58_chan_if #(.item_t(out_item_t)) char_if ();

    base58_encoder #(
        .MAX_BYTES (CAPACITY)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .char_stream (char_if)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Encoder model state
    string      glyphs = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    logic [7:0] held_bytes [CAPACITY];
    int         held_count;
    bit         held_overflow;
    out_item_t  expected_chars [$];

    // Knobs and tallies
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_req;
    int fail_count;
    int bytes_sent;
    int strings_sent;
    int chars_checked;
    int truncated_strings;
    int quiet_cycles;

    // Store one accepted byte; on the last byte, encode the string and queue its characters
    function automatic void base58_absorb(input logic [7:0] data, input logic last);
        logic [7:0] quot [CAPACITY];
        logic [5:0] digits [$];
        logic [6:0] codes [$];
        int         zeros;
        int         first;
        int         rem;
        int         v;
        bit         trunc;
        out_item_t  item;

        if (held_count < CAPACITY)
        begin
            held_bytes[held_count] = data;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (!last)
            return;

        zeros = 0;
        while (zeros < held_count && held_bytes[zeros] == 8'h00)
            zeros++;
        for (int i = 0; i < held_count; i++)
            quot[i] = held_bytes[i];

        // long division by 58 until the quotient is zero or the digit slots are full
        first = zeros;
        while (first < held_count && digits.size() < DIGIT_SLOTS)
        begin
            rem = 0;
            for (int i = first; i < held_count; i++)
            begin
                v = quot[i] + rem * 256;
                quot[i] = 8'(v / 58);
                rem = v % 58;
            end
            digits.push_back(6'(rem));
            while (first < held_count && quot[first] == 8'h00)
                first++;
        end

        // leading '1's, then digits most significant first
        for (int i = 0; i < zeros; i++)
            codes.push_back(7'(glyphs[0]));
        for (int i = digits.size() - 1; i >= 0; i--)
            codes.push_back(7'(glyphs[digits[i]]));
        trunc = held_overflow || codes.size() > MAX_CHARS;
        while (codes.size() > MAX_CHARS)
            void'(codes.pop_back());

        foreach (codes[i])
        begin
            item.char_code = codes[i];
            item.last_char = (i == codes.size() - 1);
            item.truncated = trunc;
            expected_chars.push_back(item);
        end
        if (trunc)
            truncated_strings++;
        strings_sent++;
        held_count = 0;
        held_overflow = 1'b0;
    endfunction

    // Offer one byte request with random idle gaps; valid stays high into the next one
    task automatic push_byte(input logic [7:0] data, input logic last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.payload <= '{data_byte: data, last_byte: last};
        do
            @(posedge clk);
        while (!(byte_if.valid && byte_if.ready));
        bytes_sent++;
        base58_absorb(data, last);
    endtask

    task automatic push_string(input byte_q_t str);
        for (int i = 0; i < str.size(); i++)
            push_byte(str[i], i == str.size() - 1);
    endtask

    // Sender goes quiet until every queued character has come out
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Mostly short strings; some long, a few past capacity; leading and all zeros
    function automatic byte_q_t random_string();
        byte_q_t s;
        int      len;
        int      pick;
        int      nz;

        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(1, 6);
        else if (pick < 90)
            len = $urandom_range(7, 20);
        else if (pick < 97)
            len = $urandom_range(21, CAPACITY);
        else
            len = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        for (int i = 0; i < len; i++)
            s.push_back(8'($urandom_range(255)));
        pick = $urandom_range(99);
        nz = 0;
        if (pick < 5)
            nz = len;
        else if (pick < 30)
            nz = $urandom_range(1, 3);
        for (int i = 0; i < nz && i < len; i++)
            s[i] = 8'h00;
        return s;
    endfunction

    // Single-byte extremes, digit boundary, zeros, leading zeros
    task automatic test_directed();
        byte_q_t s;
        s = {8'h00};              push_string(s);
        s = {8'hFF};              push_string(s);
        s = {8'h39};              push_string(s);
        s = {8'h3A};              push_string(s);
        s = {8'h00, 8'h00, 8'h00}; push_string(s);
        s = {8'h00, 8'h00, 8'h01}; push_string(s);
        s = {8'h01, 8'h00};       push_string(s);
        s = {8'h00, 8'hFF, 8'hFF}; push_string(s);
    endtask

    // Full store at the largest value, then a string whose tail is dropped
    task automatic test_capacity();
        byte_q_t s;
        s = {};
        for (int i = 0; i < CAPACITY; i++)
            s.push_back(8'hFF);
        push_string(s);
        s = {};
        for (int i = 0; i < CAPACITY + 2; i++)
            s.push_back(8'($urandom_range(1, 255)));
        push_string(s);
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int n = 0; n < 5; n++)
            push_string(random_string());
    endtask

    // Sender waits for each encoding to finish before the next string
    task automatic test_sender_pause();
        for (int n = 0; n < 4; n++)
        begin
            push_string(random_string());
            wait_drained();
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int stop_at;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            push_string(random_string());
    endtask

    // Receiver ready, with the long hold-off counted here
    initial
    begin
        char_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                char_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                char_if.ready <= (receiver_stall_pct == 0) ||
                                 ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare each accepted character with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_if.valid && char_if.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("char_code: expected none, got 0x%0h", char_if.payload.char_code);
                fail_count++;
            end
            else
            begin
                if (char_if.payload.char_code !== expected_chars[0].char_code)
                begin
                    $error("char_code: expected 0x%0h, got 0x%0h",
                           expected_chars[0].char_code, char_if.payload.char_code);
                    fail_count++;
                end
                if (char_if.payload.last_char !== expected_chars[0].last_char)
                begin
                    $error("last_char: expected %0b, got %0b",
                           expected_chars[0].last_char, char_if.payload.last_char);
                    fail_count++;
                end
                if (char_if.payload.truncated !== expected_chars[0].truncated)
                begin
                    $error("truncated: expected %0b, got %0b",
                           expected_chars[0].truncated, char_if.payload.truncated);
                    fail_count++;
                end
                void'(expected_chars.pop_front());
                chars_checked++;
            end
        end
    end

    // Watchdog: too long with nothing accepted on either side
    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Test sequence
    initial
    begin
        byte_if.valid <= 1'b0;
        byte_if.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_capacity();
        test_output_hold();
        test_sender_pause();
        test_random_phase(0, 0, 40);
        test_random_phase(57, 0, 40);
        test_random_phase(0, 57, 40);
        test_random_phase(25, 25, 40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Encoded %0d strings from %0d bytes; %0d characters checked.",
                 strings_sent, bytes_sent, chars_checked);
        $display("Strings with dropped bytes: %0d; idle mixes: none, sender, receiver, both.",
                 truncated_strings);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
